// ===== rtl/core/spft_pkg.sv =====
// Shared types and codes for the stream progress frontier tracker.
// No dependencies; imported by the tracker core and its checker.
`default_nettype none

package spft_pkg;

   // transaction function codes on the request side
   localparam logic [2:0] FUNC_EPOCH    = 3'd0;
   localparam logic [2:0] FUNC_POSITION = 3'd1;
   localparam logic [2:0] FUNC_CHART    = 3'd2;
   localparam logic [2:0] FUNC_ATTITUDE = 3'd3;
   localparam logic [2:0] FUNC_SYNTH    = 3'd4;
   localparam logic [2:0] FUNC_BOTTOM   = 3'd5;
   localparam logic [2:0] FUNC_OPENING  = 3'd6;
   localparam logic [2:0] FUNC_CLEAR    = 3'd7;

   // notice kinds on the response side
   localparam logic [2:0] KIND_EPOCH    = 3'd0;
   localparam logic [2:0] KIND_POSITION = 3'd1;
   localparam logic [2:0] KIND_CHART    = 3'd2;
   localparam logic [2:0] KIND_SONAR    = 3'd3;
   localparam logic [2:0] KIND_RECT     = 3'd4;
   localparam logic [2:0] KIND_MOSAIC   = 3'd5;

   // control register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_EMIT_ENABLE  = 2'd0;
   localparam logic [1:0] REG_SEPARATE     = 2'd1;
   localparam logic [1:0] REG_ATT_EXPECTED = 2'd2;

   localparam int MAX_NOTICES = 6;
   localparam int NOTE_BITS   = 32;

   typedef struct packed {
      logic [2:0]           kind;
      logic [NOTE_BITS-1:0] value;
   } notice_type;

endpackage

`default_nettype wire

// ===== rtl/core/stream_progress_frontier_tracker.sv =====
// Stream progress frontier tracker: stream marks, readiness frontiers, notice queue.
// Depends on spft_pkg.
//
//  channel | dir | payload                                   | handshake
//  req_    | in  | tuser=func, tdata=index,flag              | tvalid/tready
//  rsp_    | out | tuser=notice_kind, tdata=index, tlast     | tvalid/tready
//  csr_    | in  | 3 control registers at 0x0, 0x4, 0x8      | APB, pready tied high
//
// A transaction is registered, then evaluated combinationally into a 6-deep notice queue.
// Notices leave one per cycle while rsp_tready is high.
// The next request is taken while the previous item's notices drain (one-entry skid).
// reset clears all marks, frontiers and the queue; emit_enable returns to 1.
`default_nettype none

module stream_progress_frontier_tracker #(
   parameter int INDEX_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   // request: tdata[31:0] index, tdata[32] flag, tdata[39:33] zero
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,
   // tuser[2:0] func
   input  wire  [2:0]  req_tuser,
   // response: tdata[31:0] notice_index
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,
   // tuser[2:0] notice_kind
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   // control registers
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [3:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import spft_pkg::*;

   localparam int MW = (INDEX_BITS < 32) ? INDEX_BITS : 32;

   // control registers
   logic emit_en_ff, emit_en_in;
   logic sep_ff, sep_in;
   logic att_exp_ff, att_exp_in;

   // input register
   logic          in_vld_ff, in_vld_in;
   logic [2:0]    in_func_ff, in_func_in;
   logic [MW-1:0] in_idx_ff, in_idx_in;
   logic          in_flag_ff, in_flag_in;

   // tracker state
   logic [MW-1:0] epoch_ff, epoch_in, pos_ff, pos_in, chart_ff, chart_in;
   logic [MW-1:0] att_ff, att_in, synth_ff, synth_in, bottom_ff, bottom_in;
   logic [MW-1:0] sonar_ff, sonar_in, rect_ff, rect_in, mosaic_ff, mosaic_in;
   logic          opening_ff, opening_in;

   // notice queue, head at entry 0
   notice_type note_ff [MAX_NOTICES];
   notice_type note_in [MAX_NOTICES];
   logic [2:0] count_ff, count_in;

   // evaluation results
   logic [MW-1:0] e, p, c, a, s, b, sf, rf, mf, idx, sel, attx, cand;
   logic          fo, restart, changed, gate, stream_upd;
   notice_type    nw [MAX_NOTICES];
   logic [2:0]    cnt;

   logic process, pop, csr_wr;

   assign pop     = (count_ff != 3'd0) && rsp_tready;
   assign process = in_vld_ff && ((count_ff == 3'd0) || ((count_ff == 3'd1) && rsp_tready));

   assign req_tready = !in_vld_ff || process;
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = note_ff[0].value;
   assign rsp_tuser  = note_ff[0].kind;
   assign rsp_tlast  = (count_ff == 3'd1);

   // ---------------- control port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      emit_en_in = emit_en_ff;
      sep_in     = sep_ff;
      att_exp_in = att_exp_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_EMIT_ENABLE:  emit_en_in = csr_pwdata[0];
            REG_SEPARATE:     sep_in     = csr_pwdata[0];
            REG_ATT_EXPECTED: att_exp_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_EMIT_ENABLE:  csr_prdata = {31'd0, emit_en_ff};
         REG_SEPARATE:     csr_prdata = {31'd0, sep_ff};
         REG_ATT_EXPECTED: csr_prdata = {31'd0, att_exp_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // ---------------- input register ----------------
   always_comb begin
      in_vld_in  = in_vld_ff;
      in_func_in = in_func_ff;
      in_idx_in  = in_idx_ff;
      in_flag_in = in_flag_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in  = 1'b1;
         in_func_in = req_tuser;
         in_idx_in  = req_tdata[MW-1:0];
         in_flag_in = req_tdata[32];
      end else if (process) begin
         in_vld_in = 1'b0;
      end
   end

   // ---------------- evaluation ----------------
   always_comb begin
      e = epoch_ff;  p = pos_ff;   c = chart_ff;
      a = att_ff;    s = synth_ff; b = bottom_ff;
      sf = sonar_ff; rf = rect_ff; mf = mosaic_ff;
      fo = opening_ff;
      idx = in_idx_ff;
      cnt = 3'd0;
      gate = 1'b0;
      changed = 1'b0;
      attx = '0;
      cand = '0;
      for (int i = 0; i < MAX_NOTICES; i++) begin
         nw[i] = '0;
      end

      stream_upd = (in_func_ff <= FUNC_SYNTH);
      unique case (in_func_ff)
         FUNC_EPOCH:    sel = e;
         FUNC_POSITION: sel = p;
         FUNC_CHART:    sel = c;
         FUNC_ATTITUDE: sel = a;
         FUNC_SYNTH:    sel = s;
         default:       sel = '0;
      endcase

      // a lower index restarts the session
      restart = stream_upd && (idx < sel);
      if (restart || (in_func_ff == FUNC_CLEAR)) begin
         e = '0; p = '0; c = '0; a = '0; s = '0; b = '0;
         sf = '0; rf = '0; mf = '0;
         fo = 1'b0;
         sel = '0;
      end

      if (stream_upd) begin
         changed = (sel != idx);
         unique case (in_func_ff)
            FUNC_EPOCH:    e = idx;
            FUNC_POSITION: p = idx;
            FUNC_CHART:    c = idx;
            FUNC_ATTITUDE: a = idx;
            default:       s = idx;
         endcase
      end else if ((in_func_ff == FUNC_BOTTOM) && (idx >= b)) begin
         changed = (b != idx);
         b = idx;
      end
      gate = emit_en_ff && changed && (sep_ff || !fo);

      if (in_func_ff == FUNC_OPENING) begin
         fo = in_flag_ff;
      end

      attx = (a > s) ? a : s;

      case (in_func_ff)
         FUNC_EPOCH: begin
            if (gate) begin
               nw[cnt] = '{KIND_EPOCH, NOTE_BITS'(e)}; cnt = cnt + 3'd1;
            end
         end
         FUNC_POSITION: begin
            if (gate) begin
               nw[cnt] = '{KIND_POSITION, NOTE_BITS'(p)}; cnt = cnt + 3'd1;
               if (sf > rf) begin
                  rf = sf; nw[cnt] = '{KIND_RECT, NOTE_BITS'(rf)}; cnt = cnt + 3'd1;
               end
               cand = (att_exp_ff && attx < p) ? attx : p;
               if (cand > sf) begin
                  sf = cand; nw[cnt] = '{KIND_SONAR, NOTE_BITS'(sf)}; cnt = cnt + 3'd1;
               end
               cand = (b < c) ? b : c;
               if (attx < cand) cand = attx;
               if (sf < cand) cand = sf;
               if (cand > mf) begin
                  mf = cand; nw[cnt] = '{KIND_MOSAIC, NOTE_BITS'(mf)}; cnt = cnt + 3'd1;
               end
            end
         end
         FUNC_CHART: begin
            if (gate) begin
               nw[cnt] = '{KIND_CHART, NOTE_BITS'(c)}; cnt = cnt + 3'd1;
               if (sf > rf) begin
                  rf = sf; nw[cnt] = '{KIND_RECT, NOTE_BITS'(rf)}; cnt = cnt + 3'd1;
               end
               cand = (b < c) ? b : c;
               if (attx < cand) cand = attx;
               if (sf < cand) cand = sf;
               if (cand > mf) begin
                  mf = cand; nw[cnt] = '{KIND_MOSAIC, NOTE_BITS'(mf)}; cnt = cnt + 3'd1;
               end
            end
         end
         FUNC_ATTITUDE, FUNC_SYNTH: begin
            if (gate) begin
               cand = (att_exp_ff && attx < p) ? attx : p;
               if (cand > sf) begin
                  sf = cand; nw[cnt] = '{KIND_SONAR, NOTE_BITS'(sf)}; cnt = cnt + 3'd1;
               end
               if (sf > rf) begin
                  rf = sf; nw[cnt] = '{KIND_RECT, NOTE_BITS'(rf)}; cnt = cnt + 3'd1;
               end
               cand = (b < c) ? b : c;
               if (attx < cand) cand = attx;
               if (sf < cand) cand = sf;
               if (cand > mf) begin
                  mf = cand; nw[cnt] = '{KIND_MOSAIC, NOTE_BITS'(mf)}; cnt = cnt + 3'd1;
               end
            end
         end
         FUNC_BOTTOM: begin
            if (gate) begin
               cand = (b < c) ? b : c;
               if (attx < cand) cand = attx;
               if (sf < cand) cand = sf;
               if (cand > mf) begin
                  mf = cand; nw[cnt] = '{KIND_MOSAIC, NOTE_BITS'(mf)}; cnt = cnt + 3'd1;
               end
            end
         end
         FUNC_OPENING: begin
            // end of file opening flushes epoch, position, chart and any advanced frontiers
            if (!in_flag_ff && !sep_ff && emit_en_ff) begin
               nw[0] = '{KIND_EPOCH, NOTE_BITS'(e)};
               nw[1] = '{KIND_POSITION, NOTE_BITS'(p)};
               nw[2] = '{KIND_CHART, NOTE_BITS'(c)};
               cnt = 3'd3;
               cand = (att_exp_ff && attx < p) ? attx : p;
               if (cand > sf) begin
                  sf = cand; nw[cnt] = '{KIND_SONAR, NOTE_BITS'(sf)}; cnt = cnt + 3'd1;
               end
               cand = (b < c) ? b : c;
               if (attx < cand) cand = attx;
               if (sf < cand) cand = sf;
               if (cand > mf) begin
                  mf = cand; nw[cnt] = '{KIND_MOSAIC, NOTE_BITS'(mf)}; cnt = cnt + 3'd1;
               end
               if (sf > rf) begin
                  rf = sf; nw[cnt] = '{KIND_RECT, NOTE_BITS'(rf)}; cnt = cnt + 3'd1;
               end
            end
         end
         default: ;
      endcase
   end

   // ---------------- state and queue update ----------------
   always_comb begin
      epoch_in = epoch_ff; pos_in = pos_ff; chart_in = chart_ff;
      att_in = att_ff; synth_in = synth_ff; bottom_in = bottom_ff;
      sonar_in = sonar_ff; rect_in = rect_ff; mosaic_in = mosaic_ff;
      opening_in = opening_ff;
      count_in = count_ff;
      for (int i = 0; i < MAX_NOTICES; i++) begin
         note_in[i] = note_ff[i];
      end
      if (process) begin
         epoch_in = e; pos_in = p; chart_in = c;
         att_in = a; synth_in = s; bottom_in = b;
         sonar_in = sf; rect_in = rf; mosaic_in = mf;
         opening_in = fo;
         count_in = cnt;
         for (int i = 0; i < MAX_NOTICES; i++) begin
            note_in[i] = nw[i];
         end
      end else if (pop) begin
         count_in = count_ff - 3'd1;
         for (int i = 0; i < MAX_NOTICES - 1; i++) begin
            note_in[i] = note_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_en_ff <= 1'b1;
         sep_ff     <= 1'b0;
         att_exp_ff <= 1'b0;
         in_vld_ff  <= 1'b0;
         count_ff   <= 3'd0;
         epoch_ff   <= '0;
         pos_ff     <= '0;
         chart_ff   <= '0;
         att_ff     <= '0;
         synth_ff   <= '0;
         bottom_ff  <= '0;
         sonar_ff   <= '0;
         rect_ff    <= '0;
         mosaic_ff  <= '0;
         opening_ff <= 1'b0;
      end else begin
         emit_en_ff <= emit_en_in;
         sep_ff     <= sep_in;
         att_exp_ff <= att_exp_in;
         in_vld_ff  <= in_vld_in;
         count_ff   <= count_in;
         epoch_ff   <= epoch_in;
         pos_ff     <= pos_in;
         chart_ff   <= chart_in;
         att_ff     <= att_in;
         synth_ff   <= synth_in;
         bottom_ff  <= bottom_in;
         sonar_ff   <= sonar_in;
         rect_ff    <= rect_in;
         mosaic_ff  <= mosaic_in;
         opening_ff <= opening_in;
      end
   end

   always_ff @(posedge clock) begin
      in_func_ff <= in_func_in;
      in_idx_ff  <= in_idx_in;
      in_flag_ff <= in_flag_in;
      for (int i = 0; i < MAX_NOTICES; i++) begin
         note_ff[i] <= note_in[i];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/spft_checker.sv =====
// Port-level checks for the stream progress frontier tracker, bound to the top level.
// Depends on spft_pkg.
`default_nettype none

module spft_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata,
   input wire [2:0]  rsp_tuser,
   input wire        rsp_tlast,
   input wire        csr_pready
);
   import spft_pkg::*;

   // a stalled notice holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled notice changed");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= KIND_MOSAIC))
      else $error("notice kind out of range");

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("notice pending after reset");

   a_pready: assert property (@(posedge clock)
      csr_pready)
      else $error("pready low");

endmodule

bind stream_progress_frontier_tracker spft_checker u_spft_checker (.*);

`default_nettype wire
